// ===== rtl/assert_macros.svh =====
// assertion macros used by the drive command smoother
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while in reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

// ===== rtl/dcs_pkg.sv =====
// types, constants and the goal scaling table of the drive command smoother
`default_nettype none
package dcs_pkg;

	// fixed point: fraction bits of goals and filtered values
	localparam int FRAC_BITS = 16;
	localparam int ONE_FIX   = 1 << FRAC_BITS;

	// gain is always q0.16, consumed two bits per cycle
	localparam int GAIN_W    = 16;
	localparam int DIGIT_W   = 2;
	localparam int DIGITS    = GAIN_W / DIGIT_W;
	localparam int CNT_W     = $clog2(DIGITS);
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd13107;

	// speed is unsigned 0..1.0, angle signed -1.0..1.0
	localparam int SPD_W     = FRAC_BITS + 1;
	localparam int ANG_W     = FRAC_BITS + 2;
	localparam int MAG_W     = FRAC_BITS + 2;
	localparam int ACC_W     = MAG_W + GAIN_W;

	// joystick magnitude scaling: round(m * 2^F / 127)
	localparam int GOAL_ENTRIES = 128;
	localparam int GOAL_DIV     = 127;
	localparam int GOAL_ROUND   = 63;

	typedef logic [SPD_W-1:0] goal_lut_t [GOAL_ENTRIES];

	function automatic goal_lut_t build_goal_lut();
		goal_lut_t lut;
		for (int i = 0; i < GOAL_ENTRIES; i++) begin
			lut[i] = SPD_W'(((i << FRAC_BITS) + GOAL_ROUND) / GOAL_DIV);
		end
		return lut;
	endfunction

	localparam goal_lut_t GOAL_LUT = build_goal_lut();

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} state_t;

	// controls for the digit-serial multipliers
	typedef struct packed {
		logic load;
		logic run;
	} mul_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/dcs_serial_mul.sv =====
// digit-serial multiplier: round(mag * gain / 2^16), two gain bits per cycle
`default_nettype none
module dcs_serial_mul
	import dcs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mul_ctrl_t         ctrl,
	input  wire logic [MAG_W-1:0]  mag,
	input  wire logic [GAIN_W-1:0] gain,
	output logic      [MAG_W-1:0]  step
);

	logic [ACC_W-1:0]  mcand_q;
	logic [GAIN_W-1:0] gain_sh_q;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  part;

	// partial product of the lowest gain digit
	always_comb begin
		part = '0;
		if (gain_sh_q[0]) part = part + mcand_q;
		if (gain_sh_q[1]) part = part + {mcand_q[ACC_W-2:0], 1'b0};
	end

	// accumulator starts at one half for rounding, multiplicand moves up a digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcand_q   <= '0;
			gain_sh_q <= '0;
			acc_q     <= '0;
		end else if (ctrl.load) begin
			mcand_q   <= ACC_W'(mag);
			gain_sh_q <= gain;
			acc_q     <= ACC_W'(1) << (GAIN_W - 1);
		end else if (ctrl.run) begin
			mcand_q   <= mcand_q << DIGIT_W;
			gain_sh_q <= gain_sh_q >> DIGIT_W;
			acc_q     <= acc_q + part;
		end
	end

	assign step = acc_q[ACC_W-1:GAIN_W];

endmodule
`default_nettype wire

// ===== rtl/drive_command_smoother.sv =====
// drive command smoother: joystick frames to smoothed speed, angle and direction codes
//
//  channel   dir  fields (lowest bit up)                          handshake
//  s_        in   tdata: frame_speed[7:0] frame_angle[15:8]       tvalid/tready
//                 tuser: has_frame
//  m_        out  tdata: speed_code[7:0] angle_code[13:8]         tvalid/tready
//                 reverse_dir[14], zero[15]
//  cfg_      in   cfg_data: smoothing_gain                        cfg_we
//
// an accepted item steps through load, 8 multiply steps (two gain bits per step in
// two shared-form serial multipliers), update and output, where the result is registered.
// the next item is taken only after the sequencer returns to idle: one item at a time.
// a stalled output holds the sequencer in its output state; the input waits.
// arst_n clears the state, the filters, the goals and loads the reset gain.
`default_nettype none
`include "assert_macros.svh"
module drive_command_smoother
	import dcs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // frame_speed[7:0], frame_angle[15:8]
	input  wire logic        s_tuser,   // has_frame
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // speed_code[7:0], angle_code[13:8], reverse_dir[14]
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data
);

	state_t state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [GAIN_W-1:0] gain_q;
	logic [SPD_W-1:0]  speed_goal_q, speed_val_q;
	logic [ANG_W-1:0]  angle_goal_q, angle_val_q;
	logic              backward_q, moving_q;
	logic              sneg_q, aneg_q;
	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;

	logic              accept, out_free, out_load;
	mul_ctrl_t         mul_ctrl;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_data;
		end
	end

	// frame decode: magnitudes clipped to 127, scaled by table
	logic [7:0]       sp_raw, an_raw, sp_abs, an_abs;
	logic [6:0]       sp_mag, an_mag;
	logic [SPD_W-1:0] an_scaled;
	logic [ANG_W-1:0] an_goal;

	always_comb begin
		sp_raw    = s_tdata[7:0];
		an_raw    = s_tdata[15:8];
		sp_abs    = sp_raw[7] ? (~sp_raw + 8'd1) : sp_raw;
		an_abs    = an_raw[7] ? (~an_raw + 8'd1) : an_raw;
		sp_mag    = sp_abs[7] ? 7'd127 : sp_abs[6:0];
		an_mag    = an_abs[7] ? 7'd127 : an_abs[6:0];
		an_scaled = GOAL_LUT[an_mag];
		an_goal   = an_raw[7] ? (ANG_W'(0) - ANG_W'(an_scaled)) : ANG_W'(an_scaled);
	end

	// differences toward the goals and their magnitudes
	logic [SPD_W:0]   sdiff;
	logic [ANG_W:0]   adiff;
	logic [MAG_W-1:0] smag, amag;
	logic [ANG_W:0]   adiff_abs;
	logic [SPD_W:0]   sdiff_abs;

	always_comb begin
		sdiff     = {1'b0, speed_goal_q} - {1'b0, speed_val_q};
		adiff     = {angle_goal_q[ANG_W-1], angle_goal_q} - {angle_val_q[ANG_W-1], angle_val_q};
		sdiff_abs = sdiff[SPD_W] ? (~sdiff + 1'b1) : sdiff;
		adiff_abs = adiff[ANG_W] ? (~adiff + 1'b1) : adiff;
		smag      = MAG_W'(sdiff_abs);
		amag      = adiff_abs[MAG_W-1:0];
	end

	// serial multipliers for the two filter steps
	logic [MAG_W-1:0] sstep, astep;

	dcs_serial_mul u_speed_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mul_ctrl),
		.mag    (smag),
		.gain   (gain_q),
		.step   (sstep)
	);

	dcs_serial_mul u_angle_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mul_ctrl),
		.mag    (amag),
		.gain   (gain_q),
		.step   (astep)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_MUL;
			ST_MUL:  if (cnt_q == CNT_W'(DIGITS - 1)) state_d = ST_FIN;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		out_free      = !m_tvalid_q || m_tready;
		s_tready      = (state_q == ST_IDLE);
		accept        = s_tvalid && s_tready;
		mul_ctrl.load = (state_q == ST_LOAD);
		mul_ctrl.run  = (state_q == ST_MUL);
		out_load      = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) cnt_q <= '0;
			else if (state_q == ST_MUL) cnt_q <= cnt_q + 1'b1;
		end
	end

	// goals, direction and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_goal_q <= '0;
			angle_goal_q <= '0;
			speed_val_q  <= '0;
			angle_val_q  <= '0;
			backward_q   <= 1'b0;
			moving_q     <= 1'b0;
			sneg_q       <= 1'b0;
			aneg_q       <= 1'b0;
		end else begin
			if (accept && s_tuser) begin
				speed_goal_q <= GOAL_LUT[sp_mag];
				angle_goal_q <= an_goal;
				backward_q   <= sp_raw[7];
				moving_q     <= (sp_raw != 8'd0);
			end
			if (state_q == ST_LOAD) begin
				sneg_q <= sdiff[SPD_W];
				aneg_q <= adiff[ANG_W];
			end
			if (state_q == ST_FIN) begin
				speed_val_q <= sneg_q ? (speed_val_q - SPD_W'(sstep))
					: (speed_val_q + SPD_W'(sstep));
				angle_val_q <= aneg_q ? (angle_val_q - ANG_W'(astep))
					: (angle_val_q + ANG_W'(astep));
			end
		end
	end

	// output codes: speed * 255 and (angle + 1) * 63 / 2, both rounded
	logic [SPD_W+7:0] spd_prod;
	logic [ANG_W-1:0] ang_off;
	logic [ANG_W+5:0] ang_prod;
	logic [7:0]       speed_code;
	logic [5:0]       angle_code;
	logic             reverse_dir;

	always_comb begin
		spd_prod    = {speed_val_q, 8'd0} - (SPD_W+8)'(speed_val_q)
			+ ((SPD_W+8)'(1) << (FRAC_BITS - 1));
		ang_off     = angle_val_q + ANG_W'(ONE_FIX);
		ang_prod    = {ang_off, 6'd0} - (ANG_W+6)'(ang_off)
			+ ((ANG_W+6)'(1) << FRAC_BITS);
		speed_code  = moving_q ? spd_prod[FRAC_BITS+7:FRAC_BITS] : 8'd0;
		angle_code  = ang_prod[FRAC_BITS+6:FRAC_BITS+1];
		reverse_dir = moving_q && backward_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {1'b0, reverse_dir, angle_code, speed_code};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	`ASSERT_CLK(a_accept_loads, (s_tvalid && s_tready) |=> (state_q == ST_LOAD), "accepted item did not start loading")
	`ASSERT_CLK(a_result_from_out, $rose(m_tvalid) |-> $past(state_q == ST_OUT), "result raised outside output state")
	`ASSERT_NEVER(a_speed_range, speed_val_q > SPD_W'(ONE_FIX), "filtered speed beyond full scale")
	`ASSERT_CLK(a_mul_to_fin, (state_q == ST_FIN) |-> $past(state_q == ST_MUL && cnt_q == CNT_W'(DIGITS - 1)), "update before all multiply steps")

endmodule
`default_nettype wire
